/* rtl/core/psvm_pkg.sv */
package psvm_pkg;

  localparam int POS_W   = 24;
  localparam int SPD_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int SMP_W   = 16;
  localparam int PROD_W  = 33;
  localparam int CFG_W   = 13;

  localparam logic [2:0] FUNC_TRIGGER  = 3'd0;
  localparam logic [2:0] FUNC_STOP_ALL = 3'd1;
  localparam logic [2:0] FUNC_RENDER   = 3'd2;
  localparam logic [2:0] FUNC_ADVANCE  = 3'd3;
  localparam logic [2:0] FUNC_LOAD     = 3'd4;

  localparam logic [1:0] CFG_FRAME_COUNT = 2'd0;
  localparam logic [1:0] CFG_STEREO      = 2'd1;
  localparam logic [1:0] CFG_BLOCK_LEN   = 2'd2;

  typedef struct packed {
    logic [2:0]         func;
    logic [15:0]        speed;
    logic [15:0]        gain_left;
    logic [15:0]        gain_right;
    logic               retrigger;
    logic               channel;
    logic [12:0]        load_address;
    logic signed [15:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mix_sample;
    logic               last;
    logic [3:0]         voices_playing;
    logic               rejected;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0]  pos;
    logic [SPD_W-1:0]  spd;
    logic [GAIN_W-1:0] gain_l;
    logic [GAIN_W-1:0] gain_r;
    logic              stop;
  } voice_t;

  typedef struct packed {
    logic start;
    logic done;
  } div_ctl_t;

endpackage

/* rtl/core/psvm_ram.sv */
module psvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/psvm_span.sv */
module psvm_span
  import psvm_pkg::*;
#(
  parameter int NW = 7,
  parameter int DW = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  div_ctl_t         ctl_in,
  input  logic [DW-1:0]    dividend,
  input  logic [SPD_W-1:0] divisor,
  output logic [NW-1:0]    quo,
  output div_ctl_t         ctl_out
);

  localparam int CW = (NW + SPD_W > DW) ? NW + SPD_W : DW;

  logic             busy;
  logic             done_r;
  logic [NW-1:0]    mask;
  logic [DW-1:0]    d;
  logic [SPD_W-1:0] s;
  logic [NW-1:0]    trial;
  logic [CW-1:0]    trial_prod;

  // one quotient bit a cycle, msb first: keep the bit if trial*divisor fits
  assign trial      = quo | mask;
  assign trial_prod = CW'(trial) * CW'(s);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl_in.start) begin
        busy <= 1'b1;
        mask <= {1'b1, {(NW-1){1'b0}}};
        quo  <= '0;
        d    <= dividend;
        s    <= divisor;
      end else if (busy) begin
        if (trial_prod <= CW'(d)) begin
          quo <= trial;
        end
        mask <= mask >> 1;
        if (mask == NW'(1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign ctl_out = '{start: 1'b0, done: done_r};

endmodule

/* rtl/core/psvm_fade_div.sv */
module psvm_fade_div
  import psvm_pkg::*;
#(
  parameter int NUM_W = 41,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  div_ctl_t         ctl_in,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output div_ctl_t         ctl_out
);

  localparam int STEP  = 8;
  localparam int NSTEP = (NUM_W + STEP - 1) / STEP;
  localparam int PADW  = NSTEP * STEP;
  localparam int CNTW  = $clog2(NSTEP + 1);

  logic [CNTW-1:0]  cnt;
  logic             done_r;
  logic [PADW-1:0]  n_sh;
  logic [PADW-1:0]  q_sh;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] d;
  logic [PADW-1:0]  n_nx;
  logic [PADW-1:0]  q_nx;
  logic [DEN_W-1:0] r_nx;

  // restoring division, eight quotient bits a cycle
  always_comb begin
    logic [DEN_W:0] r_ext;
    n_nx = n_sh;
    q_nx = q_sh;
    r_nx = rem;
    for (int k = 0; k < STEP; k++) begin
      r_ext = {r_nx, n_nx[PADW-1]};
      n_nx  = n_nx << 1;
      if (r_ext >= {1'b0, d}) begin
        r_ext = r_ext - {1'b0, d};
        q_nx  = {q_nx[PADW-2:0], 1'b1};
      end else begin
        q_nx  = {q_nx[PADW-2:0], 1'b0};
      end
      r_nx = r_ext[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl_in.start) begin
        cnt  <= CNTW'(NSTEP);
        n_sh <= PADW'(num);
        q_sh <= '0;
        rem  <= '0;
        d    <= den;
      end else if (cnt != '0) begin
        n_sh <= n_nx;
        q_sh <= q_nx;
        rem  <= r_nx;
        cnt  <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quo     = q_sh[NUM_W-1:0];
  assign ctl_out = '{start: 1'b0, done: done_r};

endmodule

/* rtl/core/polyphonic_sample_voice_mixer.sv */
// Sample player mixing up to MAX_VOICES voices of one stored mono or stereo sample.
// Load the sample word by word (func load), then trigger voices, render one
// channel per block (block_len results, held to 1..MAX_BLOCK, last on the final one) and advance.
// Voice state sits in a small voice RAM, the sample in a 2*FRAME_DEPTH word RAM.
// Render first finds each voice's length, through the span divider for a voice cut
// at the sample end; then for each output sample it steps through the voices
// (voice RAM read, sample RAM read, gain multiply, accumulate), sends a stopping
// voice's fade through the iterative divider, and hands off the result. Trigger
// shifts the voice slots one by one; stop all and advance visit each voice.
// A new item is taken only once the current one is finished.
module polyphonic_sample_voice_mixer
  import psvm_pkg::*;
#(
  parameter int MAX_VOICES  = 8,
  parameter int MAX_BLOCK   = 64,
  parameter int FRAME_DEPTH = 4096
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int VW        = MAX_VOICES > 1 ? $clog2(MAX_VOICES) : 1;
  localparam int VCW       = $clog2(MAX_VOICES + 1);
  localparam int NW        = $clog2(MAX_BLOCK + 1);
  localparam int FW        = $clog2(FRAME_DEPTH + 1);
  localparam int MEM_WORDS = 2 * FRAME_DEPTH;
  localparam int AW        = $clog2(MEM_WORDS);
  localparam int TW        = POS_W + 13;
  localparam int DW        = FW + 12;
  localparam int AMW       = NW + SPD_W;
  localparam int IXW       = POS_W + 2;
  localparam int FPW       = PROD_W + NW + 1;
  localparam int ACW       = PROD_W + VCW + 1;
  localparam int VOICE_W   = $bits(voice_t);

  typedef enum logic [4:0] {
    S_IDLE, S_FINISH,
    S_T_MRD, S_T_MWR, S_T_CHK, S_T_SRD, S_T_SWR, S_T_NEW,
    S_S_RD, S_S_WR,
    S_A_RD, S_A_WR,
    S_P_RD, S_P_CHK, S_P_DIV,
    S_R_VRD, S_R_SRD, S_R_MUL, S_R_FMUL, S_R_FST, S_R_FDIV, S_R_ACC, S_R_EMIT
  } state_t;

  state_t state;

  logic [12:0]     frame_count;
  logic            stereo;
  logic [6:0]      block_len;

  logic [VCW-1:0]  count;
  logic [VCW-1:0]  v;
  logic [VCW-1:0]  w;
  logic [NW-1:0]   i;
  logic            rej;
  in_item_t        item;
  voice_t          ent;
  logic            in_range;
  logic signed [PROD_W-1:0] term;
  logic signed [FPW-1:0]    fprod;
  logic signed [ACW-1:0]    acc;
  logic [NW-1:0]   n_arr [MAX_VOICES];
  logic            emit_go;

  // memories
  logic            vram_we;
  logic [VW-1:0]   vram_waddr;
  logic [VW-1:0]   vram_raddr;
  voice_t          vram_wdata;
  logic [VOICE_W-1:0] vram_rdata;
  voice_t          vr;
  logic            sram_we;
  logic [AW-1:0]   sram_raddr;
  logic [SMP_W-1:0] sram_rdata;

  // per-voice arithmetic
  logic [FW-1:0]   frames_u;
  logic [NW-1:0]   bl_u;
  logic [AMW-1:0]  adv;
  logic            trunc;
  logic            pos_past;
  logic            keep;
  logic            last_v;
  logic [VW-1:0]   vi;
  logic [NW-1:0]   n_cur;
  logic [IXW-1:0]  idx;
  logic [SPD_W+NW-1:0] step;
  logic [GAIN_W-1:0] g;
  logic signed [PROD_W-1:0] smp_x;
  logic signed [PROD_W-1:0] gain_x;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [FPW-1:0]    fmul;
  logic            fneg;
  logic [FPW-1:0]  fmag;
  logic signed [ACW-1:0]    rnd;
  logic signed [ACW-1:0]    rq;
  logic signed [15:0]       sat;

  div_ctl_t        span_in;
  div_ctl_t        span_out;
  logic [NW-1:0]   span_q;
  logic [DW-1:0]   span_d;
  div_ctl_t        fdiv_in;
  div_ctl_t        fdiv_out;
  logic [FPW-1:0]  fdiv_q;

  assign vr = voice_t'(vram_rdata);
  assign vi = v[VW-1:0];
  assign n_cur = n_arr[vi];
  assign last_v = (v + VCW'(1)) == count;
  assign emit_go = ((state == S_R_EMIT) || (state == S_FINISH)) && (!out_valid || out_ready);

  assign frames_u = (32'(frame_count) < FRAME_DEPTH) ? FW'(frame_count) : FW'(FRAME_DEPTH);
  always_comb begin
    if (block_len == 7'd0) begin
      bl_u = NW'(1);
    end else if (32'(block_len) > MAX_BLOCK) begin
      bl_u = NW'(MAX_BLOCK);
    end else begin
      bl_u = NW'(block_len);
    end
  end

  // voice would run past the sample end within this block
  assign adv      = AMW'(bl_u) * AMW'(vr.spd);
  assign trunc    = (TW'({vr.pos, 12'b0}) + TW'(adv)) >= TW'({frames_u, 12'b0});
  assign pos_past = TW'(vr.pos) >= TW'(frames_u);
  assign keep     = !(trunc || vr.stop);
  assign span_d   = {frames_u - FW'(vr.pos), 12'b0};

  assign span_in.start = (state == S_P_CHK) && trunc && !pos_past && (vr.spd != '0);
  assign span_in.done  = 1'b0;

  assign step = (SPD_W+NW)'(vr.spd) * (SPD_W+NW)'(i);
  assign idx  = ((stereo && item.channel) ? IXW'(FRAME_DEPTH) : IXW'(0))
              + IXW'(vr.pos) + IXW'(step >> 12);

  assign g      = item.channel ? ent.gain_r : ent.gain_l;
  assign smp_x  = PROD_W'($signed(sram_rdata));
  assign gain_x = $signed(PROD_W'(g));
  assign prod_c = in_range ? smp_x * gain_x : '0;

  assign fmul = FPW'(term) * $signed(FPW'(n_cur - NW'(1) - i));
  assign fneg = fprod[FPW-1];
  assign fmag = fneg ? FPW'(-fprod) : FPW'(fprod);

  assign fdiv_in.start = (state == S_R_FST);
  assign fdiv_in.done  = 1'b0;

  // round half up then saturate to 16 bits
  assign rnd = acc + ACW'(16384);
  assign rq  = rnd >>> 15;
  always_comb begin
    if (rq > $signed(ACW'(32767))) begin
      sat = 16'sd32767;
    end else if (rq < $signed(ACW'(-32768))) begin
      sat = -16'sd32768;
    end else begin
      sat = 16'(rq);
    end
  end

  always_comb begin
    vram_we    = 1'b0;
    vram_waddr = vi;
    vram_raddr = vi;
    vram_wdata = vr;
    unique case (state)
      S_T_MRD: vram_raddr = VW'(count - VCW'(1));
      S_T_MWR: begin
        vram_we         = 1'b1;
        vram_waddr      = VW'(count - VCW'(1));
        vram_wdata.stop = 1'b1;
      end
      S_T_SRD: vram_raddr = VW'(v - VCW'(1));
      S_T_SWR: vram_we = 1'b1;
      S_T_NEW: begin
        vram_we    = 1'b1;
        vram_waddr = '0;
        vram_wdata = '{pos: '0, spd: item.speed, gain_l: item.gain_left,
                       gain_r: item.gain_right, stop: 1'b0};
      end
      S_S_WR: begin
        vram_we         = 1'b1;
        vram_wdata.stop = 1'b1;
      end
      S_A_WR: begin
        vram_we         = keep;
        vram_waddr      = w[VW-1:0];
        vram_wdata.pos  = vr.pos + POS_W'(adv >> 12);
        vram_wdata.stop = 1'b0;
      end
      default: ;
    endcase
  end

  assign sram_we    = in_valid && (state == S_IDLE) && (in_data.func == FUNC_LOAD)
                   && (32'(in_data.load_address) < MEM_WORDS);
  assign sram_raddr = idx[AW-1:0];
  assign in_ready   = (state == S_IDLE);

  psvm_ram #(.WIDTH(VOICE_W), .DEPTH(MAX_VOICES)) u_voice_ram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  psvm_ram #(.WIDTH(SMP_W), .DEPTH(MEM_WORDS)) u_sample_ram (
    .clk   (clk),
    .we    (sram_we),
    .waddr (AW'(in_data.load_address)),
    .wdata (in_data.load_value),
    .raddr (sram_raddr),
    .rdata (sram_rdata)
  );

  psvm_span #(.NW(NW), .DW(DW)) u_span (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (span_in),
    .dividend (span_d),
    .divisor  (vr.spd),
    .quo      (span_q),
    .ctl_out  (span_out)
  );

  psvm_fade_div #(.NUM_W(FPW), .DEN_W(NW)) u_fade_div (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (fdiv_in),
    .num     (fmag),
    .den     (n_cur - NW'(1)),
    .quo     (fdiv_q),
    .ctl_out (fdiv_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      out_valid   <= 1'b0;
      frame_count <= 13'd4096;
      stereo      <= 1'b0;
      block_len   <= 7'd64;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_FRAME_COUNT: frame_count <= cfg_data;
          CFG_STEREO:      stereo      <= cfg_data[0];
          CFG_BLOCK_LEN:   block_len   <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_data;
            rej  <= 1'b0;
            v    <= '0;
            w    <= '0;
            i    <= '0;
            acc  <= '0;
            if (in_data.func == FUNC_TRIGGER) begin
              state <= (in_data.retrigger && count != '0) ? S_T_MRD : S_T_CHK;
            end else if (in_data.func == FUNC_STOP_ALL) begin
              state <= (count == '0) ? S_FINISH : S_S_RD;
            end else if (in_data.func == FUNC_RENDER) begin
              state <= (count == '0) ? S_R_EMIT : S_P_RD;
            end else if (in_data.func == FUNC_ADVANCE) begin
              state <= (count == '0) ? S_FINISH : S_A_RD;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_T_MRD: state <= S_T_MWR;
        S_T_MWR: state <= S_T_CHK;
        S_T_CHK: begin
          if (count == VCW'(MAX_VOICES)) begin
            rej   <= 1'b1;
            state <= S_FINISH;
          end else begin
            v     <= count;
            state <= (count == '0) ? S_T_NEW : S_T_SRD;
          end
        end
        S_T_SRD: state <= S_T_SWR;
        S_T_SWR: begin
          v     <= v - VCW'(1);
          state <= (v == VCW'(1)) ? S_T_NEW : S_T_SRD;
        end
        S_T_NEW: begin
          count <= count + VCW'(1);
          state <= S_FINISH;
        end
        S_S_RD: state <= S_S_WR;
        S_S_WR: begin
          v     <= v + VCW'(1);
          state <= last_v ? S_FINISH : S_S_RD;
        end
        S_A_RD: state <= S_A_WR;
        S_A_WR: begin
          if (keep) begin
            w <= w + VCW'(1);
          end
          v <= v + VCW'(1);
          if (last_v) begin
            count <= w + VCW'(keep);
            state <= S_FINISH;
          end else begin
            state <= S_A_RD;
          end
        end
        S_P_RD: state <= S_P_CHK;
        S_P_CHK, S_P_DIV: begin
          if (state == S_P_CHK && span_in.start) begin
            state <= S_P_DIV;
          end else if (state == S_P_CHK || span_out.done) begin
            if (state == S_P_DIV) begin
              n_arr[vi] <= span_q;
            end else if (!trunc) begin
              n_arr[vi] <= bl_u;
            end else begin
              n_arr[vi] <= '0;
            end
            if (last_v) begin
              v     <= '0;
              state <= S_R_VRD;
            end else begin
              v     <= v + VCW'(1);
              state <= S_P_RD;
            end
          end
        end
        S_R_VRD: state <= S_R_SRD;
        S_R_SRD: begin
          ent      <= vr;
          in_range <= idx < IXW'(MEM_WORDS);
          if (i >= n_cur) begin
            if (last_v) begin
              state <= S_R_EMIT;
            end else begin
              v     <= v + VCW'(1);
              state <= S_R_VRD;
            end
          end else begin
            state <= S_R_MUL;
          end
        end
        S_R_MUL: begin
          // a stopping voice of length one plays silent
          if (ent.stop && n_cur <= NW'(1)) begin
            term <= '0;
          end else begin
            term <= prod_c;
          end
          state <= (ent.stop && n_cur > NW'(1)) ? S_R_FMUL : S_R_ACC;
        end
        S_R_FMUL: begin
          fprod <= fmul;
          state <= S_R_FST;
        end
        S_R_FST: state <= S_R_FDIV;
        S_R_FDIV: begin
          if (fdiv_out.done) begin
            term  <= fneg ? -PROD_W'(fdiv_q) : PROD_W'(fdiv_q);
            state <= S_R_ACC;
          end
        end
        S_R_ACC: begin
          acc <= acc + ACW'(term);
          if (last_v) begin
            state <= S_R_EMIT;
          end else begin
            v     <= v + VCW'(1);
            state <= S_R_VRD;
          end
        end
        S_R_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid                <= 1'b1;
            out_data.mix_sample      <= sat;
            out_data.last            <= (i + NW'(1)) == bl_u;
            out_data.voices_playing  <= 4'(count);
            out_data.rejected        <= 1'b0;
            if ((i + NW'(1)) == bl_u) begin
              state <= S_IDLE;
            end else begin
              i     <= i + NW'(1);
              acc   <= '0;
              v     <= '0;
              state <= (count == '0) ? S_R_EMIT : S_R_VRD;
            end
          end
        end
        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid               <= 1'b1;
            out_data.mix_sample     <= '0;
            out_data.last           <= 1'b1;
            out_data.voices_playing <= 4'(count);
            out_data.rejected       <= rej;
            state                   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* dv/polyphonic_sample_voice_mixer_tb.sv */
`timescale 1ns / 1ps

module polyphonic_sample_voice_mixer_tb;
  import psvm_pkg::*;

  localparam int VOICES    = 8;
  localparam int BLOCK_MAX = 64;
  localparam int DEPTH     = 4096;
  localparam int MEM_WORDS = 2 * DEPTH;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 60;

  class voice_mix_scoreboard;
    logic signed [15:0] sample_mem [MEM_WORDS];
    bit                 sample_written [MEM_WORDS];
    logic [23:0]        pos [VOICES];
    logic [15:0]        spd [VOICES];
    logic [15:0]        gain_l [VOICES];
    logic [15:0]        gain_r [VOICES];
    bit                 stopping [VOICES];
    int unsigned        count;
    int unsigned        frame_count;
    int unsigned        stereo;
    int unsigned        block_len;
    out_item_t          expected_items [$];
    int                 errors;

    function new();
      for (int a = 0; a < MEM_WORDS; a++) begin
        sample_mem[a] = '0;
        sample_written[a] = 0;
      end
      for (int v = 0; v < VOICES; v++) begin
        pos[v] = '0;
        spd[v] = '0;
        gain_l[v] = '0;
        gain_r[v] = '0;
        stopping[v] = 0;
      end
      count = 0;
      frame_count = 4096;
      stereo = 0;
      block_len = 64;
      errors = 0;
    endfunction

    function longint frames_used();
      return (frame_count < DEPTH) ? frame_count : DEPTH;
    endfunction

    function longint block_used();
      if (block_len < 1) return 1;
      return (block_len > BLOCK_MAX) ? BLOCK_MAX : block_len;
    endfunction

    function longint span(int v, longint frames, longint bl);
      longint p;
      longint s;
      p = pos[v];
      s = spd[v];
      if ((p << 12) + bl * s < (frames << 12)) return bl;
      if (p >= frames || s == 0) return 0;
      return ((frames - p) << 12) / s;
    endfunction

    function void set_reg(logic [1:0] idx, int unsigned val);
      case (idx)
        CFG_FRAME_COUNT: frame_count = val & 13'h1fff;
        CFG_STEREO:      stereo = val & 1;
        CFG_BLOCK_LEN:   block_len = val & 7'h7f;
        default: ;
      endcase
    endfunction

    // a render must only touch sample words that were loaded since reset
    function bit render_safe(bit chan);
      longint frames;
      longint bl;
      longint n;
      longint idx;
      longint base;
      frames = frames_used();
      bl = block_used();
      for (int v = 0; v < count; v++) begin
        n = span(v, frames, bl);
        base = ((stereo & 1) ? chan * DEPTH : 0) + pos[v];
        for (longint i = 0; i < n && i < BLOCK_MAX; i++) begin
          idx = base + ((longint'(spd[v]) * i) >> 12);
          if (idx < MEM_WORDS && !sample_written[idx]) return 0;
        end
      end
      return 1;
    endfunction

    function void push(longint mix, bit last, bit rej);
      out_item_t o;
      o.mix_sample = mix[15:0];
      o.last = last;
      o.voices_playing = count[3:0];
      o.rejected = rej;
      expected_items.push_back(o);
    endfunction

    function void note(in_item_t it);
      longint acc [BLOCK_MAX];
      longint frames;
      longint bl;
      longint n;
      longint base;
      longint idx;
      longint g;
      longint p;
      longint q;
      int w;
      bit rej;
      case (it.func)
        FUNC_TRIGGER: begin
          rej = 0;
          if (it.retrigger && count > 0) stopping[count-1] = 1;
          if (count < VOICES) begin
            for (int v = count; v > 0; v--) begin
              pos[v] = pos[v-1];
              spd[v] = spd[v-1];
              gain_l[v] = gain_l[v-1];
              gain_r[v] = gain_r[v-1];
              stopping[v] = stopping[v-1];
            end
            pos[0] = '0;
            spd[0] = it.speed;
            gain_l[0] = it.gain_left;
            gain_r[0] = it.gain_right;
            stopping[0] = 0;
            count++;
          end else begin
            rej = 1;
          end
          push(0, 1, rej);
        end
        FUNC_STOP_ALL: begin
          for (int v = 0; v < count; v++) stopping[v] = 1;
          push(0, 1, 0);
        end
        FUNC_RENDER: begin
          frames = frames_used();
          bl = block_used();
          for (int i = 0; i < BLOCK_MAX; i++) acc[i] = 0;
          for (int v = 0; v < count; v++) begin
            n = span(v, frames, bl);
            base = ((stereo & 1) ? it.channel * DEPTH : 0) + pos[v];
            g = it.channel ? gain_r[v] : gain_l[v];
            for (longint i = 0; i < n && i < BLOCK_MAX; i++) begin
              idx = base + ((longint'(spd[v]) * i) >> 12);
              p = (idx < MEM_WORDS) ? longint'(sample_mem[idx]) * g : 0;
              if (stopping[v]) begin
                if (n <= 1) p = 0;
                else p = p * (n - 1 - i) / (n - 1);
              end
              acc[i] += p;
            end
          end
          for (longint i = 0; i < bl; i++) begin
            q = (acc[i] + 16384) >>> 15;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            push(q, i + 1 == bl, 0);
          end
        end
        FUNC_ADVANCE: begin
          frames = frames_used();
          bl = block_used();
          w = 0;
          for (int v = 0; v < count; v++) begin
            p = bl * spd[v];
            if ((longint'(pos[v]) << 12) + p >= (frames << 12) || stopping[v]) continue;
            pos[w] = 24'(pos[v] + (p >> 12));
            spd[w] = spd[v];
            gain_l[w] = gain_l[v];
            gain_r[w] = gain_r[v];
            stopping[w] = 0;
            w++;
          end
          count = w;
          push(0, 1, 0);
        end
        FUNC_LOAD: begin
          if (it.load_address < MEM_WORDS) begin
            sample_mem[it.load_address] = it.load_value;
            sample_written[it.load_address] = 1;
          end
          push(0, 1, 0);
        end
        default: push(0, 1, 0);
      endcase
    endfunction

    function void check(out_item_t got);
      out_item_t exp_item;
      if (expected_items.size() == 0) begin
        $error("unexpected result item %h", got);
        errors++;
        return;
      end
      exp_item = expected_items.pop_front();
      if (got.mix_sample !== exp_item.mix_sample) begin
        $error("mix_sample expected %0d actual %0d", exp_item.mix_sample, got.mix_sample);
        errors++;
      end
      if (got.last !== exp_item.last) begin
        $error("last expected %0d actual %0d", exp_item.last, got.last);
        errors++;
      end
      if (got.voices_playing !== exp_item.voices_playing) begin
        $error("voices_playing expected %0d actual %0d",
               exp_item.voices_playing, got.voices_playing);
        errors++;
      end
      if (got.rejected !== exp_item.rejected) begin
        $error("rejected expected %0d actual %0d", exp_item.rejected, got.rejected);
        errors++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_write;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  voice_mix_scoreboard mix_sb;
  int burst_left;
  int hold_left;
  int idle_cycles;

  polyphonic_sample_voice_mixer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // sender: bursts of items separated by random gaps
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    mix_sb.note(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    while (mix_sb.expected_items.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    mix_sb.set_reg(idx, val);
  endtask

  function automatic in_item_t rand_fields();
    in_item_t it;
    it.func = FUNC_STOP_ALL;
    it.speed = 16'($urandom_range(1, 65535));
    it.gain_left = 16'($urandom_range(0, 32768));
    it.gain_right = 16'($urandom_range(0, 32768));
    it.retrigger = 1'($urandom_range(0, 1));
    it.channel = 1'($urandom_range(0, 1));
    it.load_address = 13'($urandom_range(0, 8191));
    it.load_value = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  function automatic in_item_t make_load(int unsigned addr);
    in_item_t it;
    it = rand_fields();
    it.func = FUNC_LOAD;
    it.load_address = 13'(addr);
    return it;
  endfunction

  function automatic in_item_t make_trigger(int unsigned s, int unsigned gl, int unsigned gr,
                                            bit retrig);
    in_item_t it;
    it = rand_fields();
    it.func = FUNC_TRIGGER;
    it.speed = 16'(s);
    it.gain_left = 16'(gl);
    it.gain_right = 16'(gr);
    it.retrigger = retrig;
    return it;
  endfunction

  function automatic in_item_t pick_item();
    in_item_t it;
    int roll;
    int unsigned fu;
    it = rand_fields();
    roll = $urandom_range(0, 99);
    fu = 32'(mix_sb.frames_used());
    if (roll < 28) begin
      it.func = FUNC_TRIGGER;
      if ($urandom_range(0, 1)) it.speed = 16'($urandom_range(1, 2048));
      it.retrigger = ($urandom_range(0, 3) == 0);
    end else if (roll < 55) begin
      it.func = FUNC_RENDER;
    end else if (roll < 75) begin
      it.func = FUNC_ADVANCE;
    end else if (roll < 80) begin
      it.func = FUNC_STOP_ALL;
    end else if (roll < 96) begin
      it.func = FUNC_LOAD;
      if ($urandom_range(0, 3) != 0)
        it.load_address = 13'($urandom_range(0, 1) * DEPTH + $urandom_range(0, fu - 1));
    end else begin
      it.func = 3'($urandom_range(5, 7));
    end
    // a render that would read never-loaded words becomes a stop all
    if (it.func == FUNC_RENDER && !mix_sb.render_safe(it.channel)) it.func = FUNC_STOP_ALL;
    return it;
  endfunction

  task automatic run_phase(int unsigned frames, int unsigned st, int unsigned bl,
                           int n_items, bit hold_off);
    int unsigned fl;
    wait_drained();
    write_reg(CFG_FRAME_COUNT, frames);
    write_reg(CFG_STEREO, st);
    write_reg(CFG_BLOCK_LEN, bl);
    fl = (frames < 32) ? frames : 32;
    for (int c = 0; c < 2; c++)
      for (int f = 0; f < fl; f++) send_item(make_load(c * DEPTH + f));
    if (hold_off) hold_left = 3000;
    for (int k = 0; k < n_items; k++) send_item(pick_item());
  endtask

  // receiver: switches among stall patterns, with long hold-offs on request
  initial begin
    int mode;
    int mode_left;
    mode = 0;
    mode_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) mix_sb.check(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_write) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    mix_sb = new();
    burst_left = 0;
    hold_left = 0;
    idle_cycles = 0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_write <= 1'b0;
    cfg_index <= CFG_FRAME_COUNT;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: sample and speed extremes, every func, full table, retrigger, fades
    write_reg(CFG_FRAME_COUNT, 12);
    write_reg(CFG_STEREO, 1);
    write_reg(CFG_BLOCK_LEN, 16);
    for (int c = 0; c < 2; c++)
      for (int f = 0; f < 12; f++) begin
        in_item_t it;
        it = make_load(c * DEPTH + f);
        if (f == 0) it.load_value = 16'sh7fff;
        if (f == 1) it.load_value = -16'sh8000;
        send_item(it);
      end
    send_item(make_trigger(65535, 32768, 0, 0));
    send_item(make_trigger(1, 0, 32768, 1));
    for (int k = 0; k < 7; k++) send_item(make_trigger(4096, 32768, 32768, k == 6));
    begin
      in_item_t it;
      it = rand_fields();
      for (int ch = 0; ch < 2; ch++) begin
        it.func = FUNC_RENDER;
        it.channel = 1'(ch);
        send_item(it);
      end
      it.func = FUNC_STOP_ALL;
      send_item(it);
      it.func = FUNC_RENDER;
      it.channel = 0;
      send_item(it);
      it.func = FUNC_ADVANCE;
      send_item(it);
      for (int u = 5; u < 8; u++) begin
        it.func = 3'(u);
        send_item(it);
      end
    end
    send_item(make_trigger(2048, 32768, 32768, 0));
    send_item(make_load(8191));

    run_phase(12, 1, 16, 30, 0);
    run_phase(1, 1, 2, 30, 1);
    run_phase(40, 1, 64, 40, 0);
    run_phase(4096, 0, 64, 30, 0);
    run_phase(20, 0, 33, 40, 0);
    run_phase(30, 1, 2, 30, 0);

    wait_drained();
    if (mix_sb.errors == 0 && mix_sb.expected_items.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
